[design/mhtq_pkg.sv]
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types, codes and helpers of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int HeapCap  = 32;
  localparam int IdSlots  = 1024;
  localparam int TimeBits = 32;
  localparam int IdxW     = $clog2(HeapCap);
  localparam int CntW     = $clog2(HeapCap + 1);
  localparam int IdW      = 10;
  localparam int SlotAW   = $clog2(IdSlots);
  localparam int RemW     = 31;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [IdW-1:0]      id_t;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_ADJ   = 3'd1;
  localparam logic [2:0] OP_FIRE  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_NEXT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    id_t   id;
    time_t expiry;
  } heap_entry_t;

  typedef struct packed {
    logic [2:0]  op;
    id_t         timer_id;
    logic [30:0] timeout_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]      kind;
    id_t             fired_id;
    logic [RemW-1:0] remaining_ms;
    logic            has_timer;
    logic [1:0]      status;
    logic            last;
  } res_t;

  // a strictly earlier than b, by wrapped difference
  function automatic logic earlier(time_t a, time_t b);
    time_t d;
    d = a - b;
    return d[TimeBits-1];
  endfunction

  function automatic res_t mk_res(logic [1:0] kind, id_t id, logic [RemW-1:0] rem,
                                  logic has, logic [1:0] status, logic last);
    res_t r;
    r.kind         = kind;
    r.fired_id     = id;
    r.remaining_ms = rem;
    r.has_timer    = has;
    r.status       = status;
    r.last         = last;
    return r;
  endfunction

endpackage

[design/mhtq_if.sv]
// ----------------------------------------------------------------------------
// mhtq channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhtq_req_if;
  import mhtq_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  id_t         timer_id;
  logic [30:0] timeout_ms;
  logic [31:0] now_ms;

  modport source (output valid, op, timer_id, timeout_ms, now_ms, input ready);
  modport sink (input valid, op, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface mhtq_res_if;
  import mhtq_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  id_t             fired_id;
  logic [RemW-1:0] remaining_ms;
  logic            has_timer;
  logic [1:0]      status;
  logic            last;

  modport source (output valid, kind, fired_id, remaining_ms, has_timer, status, last,
                  input ready);
  modport sink (input valid, kind, fired_id, remaining_ms, has_timer, status, last,
                output ready);
endinterface

[design/mhtq_engine.sv]
// ----------------------------------------------------------------------------
// mhtq_engine
// Heap sequencer: slot lookup, sift up and sift down, root removal
// and tick scan. Heap and slot map live in local memories.
// ----------------------------------------------------------------------------
module mhtq_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  mhtq_pkg::req_t  req_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output mhtq_pkg::res_t  res_o
);
  import mhtq_pkg::*;

  typedef enum logic [14:0] {
    S_INIT   = 15'h0001,
    S_IDLE   = 15'h0002,
    S_LOOK   = 15'h0004,
    S_LOOK2  = 15'h0008,
    S_PRES   = 15'h0010,
    S_ROOT   = 15'h0020,
    S_ROOT2  = 15'h0040,
    S_EMIT   = 15'h0080,
    S_RM     = 15'h0100,
    S_RM2    = 15'h0200,
    S_DN_RD  = 15'h0400,
    S_DN_CMP = 15'h0800,
    S_UP_RD  = 15'h1000,
    S_UP_CMP = 15'h2000,
    S_PLACE  = 15'h4000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  cnt_t   count_q, count_d;
  logic [SlotAW-1:0] init_q, init_d;

  logic [2:0]  op_q, op_d;
  id_t         id_q, id_d;
  time_t       exp_q, exp_d, now_q, now_d;
  idx_t        hole_q, hole_d, start_q, start_d, cidx_q, cidx_d;
  logic        up_after_q, up_after_d, has2_q, has2_d;
  heap_entry_t v_q, v_d;
  res_t        res_q, res_d;

  heap_entry_t heap_mem [HeapCap];
  idx_t        slot_mem [IdSlots];
  heap_entry_t rd_a_q, rd_b_q;
  idx_t        slot_rd_q;

  logic        heap_we, slot_we;
  idx_t        heap_wa, heap_ra, heap_rb, slot_wd;
  heap_entry_t heap_wd;
  logic [SlotAW-1:0] slot_wa, slot_ra;

  logic [IdxW+1:0] child_w, child2_w, cnt_w;
  idx_t        par;
  cnt_t        n_rm;
  logic        present, pick_b, v_first, due;
  heap_entry_t s_ent;
  idx_t        s_idx;
  time_t       root_gap;
  state_e      done_st, fin_dn_st;

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    rd_a_q <= heap_mem[heap_ra];
    rd_b_q <= heap_mem[heap_rb];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[slot_ra];
  end

  always_comb begin
    child_w  = {1'b0, hole_q, 1'b1};
    child2_w = child_w + (IdxW+2)'(1);
    cnt_w    = (IdxW+2)'(count_q);
    par      = (hole_q - idx_t'(1)) >> 1;
    n_rm     = count_q - cnt_t'(1);
    present  = (cnt_t'(slot_rd_q) < count_q) && (rd_a_q.id == id_q);
    pick_b   = has2_q && earlier(rd_b_q.expiry, rd_a_q.expiry);
    s_ent    = pick_b ? rd_b_q : rd_a_q;
    s_idx    = pick_b ? (cidx_q + idx_t'(1)) : cidx_q;
    v_first  = pick_b ? earlier(v_q.expiry, rd_b_q.expiry)
                      : earlier(v_q.expiry, rd_a_q.expiry);
    root_gap = rd_a_q.expiry - now_q;
    due      = (root_gap == '0) || root_gap[TimeBits-1];
    done_st  = (op_q == OP_TICK) ? S_ROOT : S_IDLE;
    fin_dn_st = ((hole_q != start_q) || !up_after_q) ? S_PLACE : S_UP_RD;
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    count_d    = count_q;
    init_d     = init_q;
    op_d       = op_q;
    id_d       = id_q;
    exp_d      = exp_q;
    now_d      = now_q;
    hole_d     = hole_q;
    start_d    = start_q;
    cidx_d     = cidx_q;
    up_after_d = up_after_q;
    has2_d     = has2_q;
    v_d        = v_q;
    res_d      = res_q;
    heap_we    = 1'b0;
    heap_wa    = hole_q;
    heap_wd    = v_q;
    heap_ra    = '0;
    heap_rb    = '0;
    slot_we    = 1'b0;
    slot_wa    = v_q.id;
    slot_wd    = hole_q;
    slot_ra    = id_q;

    unique case (state_q)
      S_INIT: begin
        slot_we = 1'b1;
        slot_wa = init_q;
        slot_wd = '0;
        init_d  = init_q + SlotAW'(1);
        if (init_q == SlotAW'(IdSlots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = req_i.op;
          id_d  = req_i.timer_id;
          now_d = req_i.now_ms;
          exp_d = req_i.now_ms + {1'b0, req_i.timeout_ms};
          unique case (req_i.op)
            OP_ADD, OP_ADJ, OP_FIRE: state_d = S_LOOK;
            OP_TICK, OP_POP:         state_d = S_ROOT;
            OP_CLEAR: begin
              count_d = '0;
              res_d   = mk_res(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end
            default: begin
              res_d   = mk_res(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
              ret_d   = S_IDLE;
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_LOOK: begin
        slot_ra = id_q;
        state_d = S_LOOK2;
      end
      S_LOOK2: begin
        heap_ra = slot_rd_q;
        state_d = S_PRES;
      end
      S_PRES: begin
        v_d     = '{id: id_q, expiry: exp_q};
        hole_d  = slot_rd_q;
        start_d = slot_rd_q;
        state_d = S_EMIT;
        ret_d   = S_IDLE;
        res_d   = mk_res(KIND_ACK, '0, '0, 1'b0, ST_ABSENT, 1'b1);
        priority if (op_q == OP_ADD) begin
          if (present) begin
            up_after_d = 1'b1;
            res_d      = mk_res(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
            ret_d      = S_DN_RD;
          end else if (count_q >= cnt_t'(HeapCap)) begin
            res_d = mk_res(KIND_ACK, '0, '0, 1'b0, ST_FULL, 1'b1);
          end else begin
            hole_d  = count_q[IdxW-1:0];
            start_d = count_q[IdxW-1:0];
            count_d = count_q + cnt_t'(1);
            res_d   = mk_res(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
            ret_d   = S_UP_RD;
          end
        end else if (op_q == OP_ADJ) begin
          if (present) begin
            up_after_d = 1'b0;
            res_d      = mk_res(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
            ret_d      = S_DN_RD;
          end
        end else begin
          if (present) begin
            res_d = mk_res(KIND_FIRED, id_q, '0, 1'b0, ST_OK, 1'b1);
            ret_d = S_RM;
          end
        end
      end
      S_ROOT: begin
        heap_ra = '0;
        if (count_q == '0) begin
          ret_d   = S_IDLE;
          state_d = S_EMIT;
          if (op_q == OP_TICK) begin
            res_d = mk_res(KIND_NEXT, '0, '0, 1'b0, ST_OK, 1'b1);
          end else begin
            res_d = mk_res(KIND_ACK, '0, '0, 1'b0, ST_EMPTY, 1'b1);
          end
        end else begin
          state_d = S_ROOT2;
        end
      end
      S_ROOT2: begin
        hole_d  = '0;
        state_d = S_EMIT;
        if (op_q != OP_TICK) begin
          res_d = mk_res(KIND_FIRED, rd_a_q.id, '0, 1'b0, ST_OK, 1'b1);
          ret_d = S_RM;
        end else if (due) begin
          res_d = mk_res(KIND_FIRED, rd_a_q.id, '0, 1'b0, ST_OK, 1'b0);
          ret_d = S_RM;
        end else begin
          res_d = mk_res(KIND_NEXT, '0, root_gap[RemW-1:0], 1'b1, ST_OK, 1'b1);
          ret_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = ret_q;
        end
      end
      S_RM: begin
        count_d = n_rm;
        heap_ra = n_rm[IdxW-1:0];
        if (cnt_t'(hole_q) < n_rm) begin
          state_d = S_RM2;
        end else begin
          state_d = done_st;
        end
      end
      S_RM2: begin
        v_d        = rd_a_q;
        start_d    = hole_q;
        up_after_d = 1'b1;
        state_d    = S_DN_RD;
      end
      S_DN_RD: begin
        heap_ra = child_w[IdxW-1:0];
        heap_rb = child2_w[IdxW-1:0];
        cidx_d  = child_w[IdxW-1:0];
        has2_d  = child2_w < cnt_w;
        if (child_w >= cnt_w) begin
          state_d = fin_dn_st;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (v_first) begin
          state_d = fin_dn_st;
        end else begin
          heap_we = 1'b1;
          heap_wd = s_ent;
          slot_we = 1'b1;
          slot_wa = s_ent.id;
          hole_d  = s_idx;
          state_d = S_DN_RD;
        end
      end
      S_UP_RD: begin
        heap_ra = par;
        if (hole_q == '0) begin
          state_d = S_PLACE;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (earlier(rd_a_q.expiry, v_q.expiry)) begin
          state_d = S_PLACE;
        end else begin
          heap_we = 1'b1;
          heap_wd = rd_a_q;
          slot_we = 1'b1;
          slot_wa = rd_a_q.id;
          hole_d  = par;
          state_d = S_UP_RD;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
        state_d = done_st;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ret_q   <= S_IDLE;
      count_q <= '0;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      count_q <= count_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    exp_q      <= exp_d;
    now_q      <= now_d;
    hole_q     <= hole_d;
    start_q    <= start_d;
    cidx_q     <= cidx_d;
    up_after_q <= up_after_d;
    has2_q     <= has2_d;
    v_q        <= v_d;
    res_q      <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

[design/min_heap_timer_queue.sv]
// Results: add/adjust/fire answer after the slot lookup and heap read, pop and tick
// after the root read, clear without any lookup; the block then stays busy for the heap sift.
// One item at a time: no new item is taken until the current one, its heap sift and
// any output stall are done; a tick fires every due timer, each with its own removal.
// Reset: heap empty; a pass over all 1024 entries then clears the id-to-slot map,
// during which no item is taken.
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Timer queue on a binary min-heap with an id-to-slot map; output register.
// ----------------------------------------------------------------------------
module min_heap_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhtq_req_if.sink    in_chan_i,
  mhtq_res_if.source  out_chan_o
);
  import mhtq_pkg::*;

  req_t req;
  res_t res, out_q;
  logic res_valid, res_ready, out_valid_q;

  assign req = '{op: in_chan_i.op, timer_id: in_chan_i.timer_id,
                 timeout_ms: in_chan_i.timeout_ms, now_ms: in_chan_i.now_ms};

  mhtq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_chan_i.valid),
    .req_ready_o (in_chan_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_chan_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.kind         = out_q.kind;
  assign out_chan_o.fired_id     = out_q.fired_id;
  assign out_chan_o.remaining_ms = out_q.remaining_ms;
  assign out_chan_o.has_timer    = out_q.has_timer;
  assign out_chan_o.status       = out_q.status;
  assign out_chan_o.last         = out_q.last;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_chan_i.ready) |=> !in_chan_i.ready)
    else $error("accepted a second item back to back");

  a_not_last_is_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && !out_chan_o.last) |-> (out_chan_o.kind == KIND_FIRED))
    else $error("non-final result that is not a fired timer");

  a_next_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && out_chan_o.kind == KIND_NEXT) |->
      (out_chan_o.status == ST_OK && out_chan_o.last))
    else $error("next-expiry report malformed");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.ready && !out_valid_q) |-> !res_valid)
    else $error("result raised while idle");

endmodule
